// ===== src/hdp_pkg.sv =====
package hdp_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Parsed fields of one date string, handed from the parser to the epoch unit.
  typedef struct packed {
    logic        err;     // malformed or too short
    logic [13:0] year;
    logic [3:0]  month;   // 0 = January
    logic [4:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } hdp_rec_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] m);
    logic [4:0] d;
    begin
      unique case (m)
        4'd1:                      d = 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
        default:                   d = 5'd31;
      endcase
      return d;
    end
  endfunction

  // 367*mon/12 - 30 - 1 - 719527 + 31 + 28, with mon rotated so March is 1.
  function automatic logic signed [20:0] month_offset(input logic [3:0] m);
    logic signed [20:0] o;
    begin
      unique case (m)
        4'd0:    o = 21'sd336 - 21'sd719499;
        4'd1:    o = 21'sd367 - 21'sd719499;
        4'd2:    o = 21'sd30  - 21'sd719499;
        4'd3:    o = 21'sd61  - 21'sd719499;
        4'd4:    o = 21'sd91  - 21'sd719499;
        4'd5:    o = 21'sd122 - 21'sd719499;
        4'd6:    o = 21'sd152 - 21'sd719499;
        4'd7:    o = 21'sd183 - 21'sd719499;
        4'd8:    o = 21'sd214 - 21'sd719499;
        4'd9:    o = 21'sd244 - 21'sd719499;
        4'd10:   o = 21'sd275 - 21'sd719499;
        default: o = 21'sd305 - 21'sd719499;
      endcase
      return o;
    end
  endfunction

endpackage

// ===== src/hdp_front.sv =====
module hdp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_i,
  input  logic             last_i,
  output logic             push_o,
  output hdp_pkg::hdp_rec_t rec_o
);
  import hdp_pkg::*;

  typedef enum logic [4:0] {
    PhWday, PhSkip, PhDay1, PhDay2, PhDaySep, PhMon1, PhMon2, PhMon3, PhMonSep,
    PhYr1, PhYr2, PhYr3, PhYr4, PhIsod0, PhIsod1, PhIsod2, PhTsep, PhHr1, PhHr2,
    PhCol1, PhMn1, PhMn2, PhCol2, PhSc1, PhSc2, PhIysep, PhDone
  } phase_e;

  typedef enum logic [1:0] {FmtNone, Fmt1123, Fmt850, FmtAsc} fmt_e;

  phase_e      phase_q, phase_d, eff;
  fmt_e        fmt_q, fmt_d;
  logic [4:0]  day_q, day_d;
  logic [7:0]  l1_q, l1_d, l2_q, l2_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_q, year_d, year_nx;
  logic [6:0]  hour_q, hour_d, min_q, min_d, sec_q, sec_d;
  logic        err_q, err_d;
  logic        dig, want_digit, day_first;
  logic [3:0]  dval;
  logic [8:0]  day_cand;

  assign dig      = (char_i >= ChZero) && (char_i <= ChNine);
  assign dval     = char_i[3:0];
  assign year_nx  = 14'(year_q * 14'd10 + 14'(dval));
  assign day_first = (eff == PhDay1) || (eff == PhIsod1);
  assign day_cand = day_first ? 9'(dval) : 9'(day_q * 9'd10 + 9'(dval));

  always_comb begin
    priority if (phase_q == PhSkip && char_i != ChSpace) begin
      eff = (fmt_q == FmtAsc) ? PhMon1 : PhDay1;
    end else if (phase_q == PhIsod0 && char_i != ChSpace) begin
      eff = PhIsod1;
    end else begin
      eff = phase_q;
    end
  end

  always_comb begin
    want_digit = (eff == PhDay1) || (eff == PhDay2) || (eff == PhYr1) || (eff == PhYr2) ||
                 (eff == PhYr3) || (eff == PhYr4) || (eff == PhIsod1) || (eff == PhHr1) ||
                 (eff == PhHr2) || (eff == PhMn1) || (eff == PhMn2) || (eff == PhSc1) ||
                 (eff == PhSc2);
    phase_d = phase_q; fmt_d = fmt_q; day_d = day_q; l1_d = l1_q; l2_d = l2_q;
    month_d = month_q; year_d = year_q; hour_d = hour_q; min_d = min_q; sec_d = sec_q;
    err_d = err_q;
    if (want_digit && !dig) begin
      err_d = 1'b1;
    end else begin
      case (eff)
        PhWday: begin
          if (char_i == ChComma) begin
            phase_d = PhSkip;
          end else if (char_i == ChSpace) begin
            fmt_d = FmtAsc;
            phase_d = PhSkip;
          end
        end
        PhDay1, PhDay2, PhIsod1: begin
          if (day_cand > 9'd31) begin
            err_d = 1'b1;
            day_d = 5'd31;
          end else begin
            day_d = day_cand[4:0];
          end
          phase_d = (eff == PhDay1) ? PhDay2 : (eff == PhDay2) ? PhDaySep : PhIsod2;
        end
        PhDaySep: begin
          if (char_i == ChSpace) fmt_d = Fmt1123;
          else if (char_i == ChDash) fmt_d = Fmt850;
          else err_d = 1'b1;
          phase_d = PhMon1;
        end
        PhMon1: begin
          if (char_i == "J" || char_i == "F" || char_i == "M" || char_i == "A" ||
              char_i == "S" || char_i == "O" || char_i == "N" || char_i == "D") begin
            l1_d = char_i;
            l2_d = '0;
            phase_d = PhMon2;
          end else begin
            err_d = 1'b1;
          end
        end
        PhMon2: begin
          l2_d = char_i;
          phase_d = PhMon3;
        end
        PhMon3: begin
          priority case (l1_q)
            "J":     month_d = (l2_q == "a") ? 4'd0 : (char_i == "n") ? 4'd5 : 4'd6;
            "F":     month_d = 4'd1;
            "M":     month_d = (char_i == "r") ? 4'd2 : 4'd4;
            "A":     month_d = (l2_q == "p") ? 4'd3 : 4'd7;
            "S":     month_d = 4'd8;
            "O":     month_d = 4'd9;
            "N":     month_d = 4'd10;
            default: month_d = 4'd11;
          endcase
          phase_d = PhMonSep;
        end
        PhMonSep: begin
          if ((fmt_q == Fmt1123 && char_i != ChSpace) || (fmt_q == Fmt850 && char_i != ChDash))
            err_d = 1'b1;
          phase_d = (fmt_q == FmtAsc) ? PhIsod0 : PhYr1;
        end
        PhYr1, PhYr2, PhYr3, PhYr4: begin
          year_d = year_nx;
          if (eff == PhYr2 && fmt_q == Fmt850) begin
            year_d = 14'(year_nx + ((year_nx < 14'd70) ? 14'd2000 : 14'd1900));
            phase_d = PhTsep;
          end else if (eff == PhYr4) begin
            phase_d = (fmt_q == FmtAsc) ? PhDone : PhTsep;
          end else begin
            phase_d = (eff == PhYr1) ? PhYr2 : (eff == PhYr2) ? PhYr3 : PhYr4;
          end
        end
        PhIsod0: phase_d = PhIsod1;
        PhIsod2: begin
          if (char_i == ChSpace) begin
            phase_d = PhHr1;
          end else if (dig) begin
            if (day_cand > 9'd31) begin
              err_d = 1'b1;
              day_d = 5'd31;
            end else begin
              day_d = day_cand[4:0];
            end
            phase_d = PhTsep;
          end else begin
            err_d = 1'b1;
          end
        end
        PhTsep, PhIysep: begin
          if (char_i != ChSpace) err_d = 1'b1;
          phase_d = (eff == PhTsep) ? PhHr1 : PhYr1;
        end
        PhHr1: begin hour_d = 7'(dval); phase_d = PhHr2; end
        PhHr2: begin hour_d = 7'(hour_q * 7'd10 + 7'(dval)); phase_d = PhCol1; end
        PhCol1, PhCol2: begin
          if (char_i != ChColon) err_d = 1'b1;
          phase_d = (eff == PhCol1) ? PhMn1 : PhSc1;
        end
        PhMn1: begin min_d = 7'(dval); phase_d = PhMn2; end
        PhMn2: begin min_d = 7'(min_q * 7'd10 + 7'(dval)); phase_d = PhCol2; end
        PhSc1: begin sec_d = 7'(dval); phase_d = PhSc2; end
        PhSc2: begin
          sec_d = 7'(sec_q * 7'd10 + 7'(dval));
          phase_d = (fmt_q == FmtAsc) ? PhIysep : PhDone;
        end
        default: ;
      endcase
    end
  end

  // An item after an error only counts toward the end of the string.
  always_comb begin
    push_o        = accept_i && last_i;
    rec_o.err     = err_q ? 1'b1 : (err_d || phase_d != PhDone);
    rec_o.year    = year_d;
    rec_o.month   = month_d;
    rec_o.day     = day_d;
    rec_o.hour    = hour_d;
    rec_o.minute  = min_d;
    rec_o.second  = sec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWday; fmt_q <= FmtNone; day_q <= '0; l1_q <= '0; l2_q <= '0;
      month_q <= '0; year_q <= '0; hour_q <= '0; min_q <= '0; sec_q <= '0; err_q <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        phase_q <= PhWday; fmt_q <= FmtNone; day_q <= '0; l1_q <= '0; l2_q <= '0;
        month_q <= '0; year_q <= '0; hour_q <= '0; min_q <= '0; sec_q <= '0; err_q <= 1'b0;
      end else if (!err_q) begin
        phase_q <= phase_d; fmt_q <= fmt_d; day_q <= day_d; l1_q <= l1_d; l2_q <= l2_d;
        month_q <= month_d; year_q <= year_d; hour_q <= hour_d; min_q <= min_d;
        sec_q <= sec_d; err_q <= err_d;
      end
    end
  end

endmodule

// ===== src/hdp_fifo.sv =====
module hdp_fifo #(
  parameter int unsigned Depth = hdp_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hdp_pkg::hdp_rec_t data_i,
  input  logic              pop_i,
  output hdp_pkg::hdp_rec_t data_o,
  output logic              full_o,
  output logic              empty_o
);
  import hdp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hdp_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== src/hdp_back.sv =====
module hdp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  hdp_pkg::hdp_rec_t rec_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [38:0]       secs_o,
  output logic              err_o
);
  import hdp_pkg::*;

  typedef enum logic [1:0] {StIdle, StQuot, StDays, StSecs} state_e;

  state_e             state_q;
  hdp_rec_t           rec_q;
  logic [13:0]        ya;
  logic               ya_neg;
  logic [13:0]        ya_q;
  logic               ya_neg_q;
  logic [6:0]         q100y_q, q100a_q;
  logic [26:0]        prod_y, prod_a;
  logic [6:0]         q400y;
  logic [13:0]        r100, r400;
  logic               leap, ok;
  logic signed [24:0] ybase, days, days_q;
  logic [19:0]        tod, tod_q;
  logic               ok_q;
  logic signed [42:0] secs_full;
  logic               load;

  // January and February count toward the previous year.
  always_comb begin
    ya_neg = (rec_q.month < 4'd2) && (rec_q.year == '0);
    ya     = (rec_q.month < 4'd2) ? 14'(rec_q.year - 14'd1) : rec_q.year;
    if (ya_neg) ya = '0;
  end

  // Divide by 100 through the reciprocal 5243 / 2^19, exact below 43699.
  assign prod_y = 27'(rec_q.year) * 27'd5243;
  assign prod_a = 27'(ya) * 27'd5243;

  always_comb begin
    q400y = q100y_q >> 2;
    r100  = 14'(rec_q.year - 14'(q100y_q * 14'd100));
    r400  = 14'(rec_q.year - 14'(q400y * 14'd400));
    leap  = (rec_q.year[1:0] == 2'd0) && !((r100 == '0) && (r400 != '0));
    ok    = !rec_q.err && rec_q.hour <= 7'd23 && rec_q.minute <= 7'd59 &&
            rec_q.second <= 7'd59;
    if (rec_q.day == 5'd29 && rec_q.month == 4'd1) begin
      if (!leap) ok = 1'b0;
    end else if (rec_q.day > days_in_month(rec_q.month)) begin
      ok = 1'b0;
    end
    ybase = ya_neg_q ? -25'sd365
                     : 25'(ya_q * 25'd365 + 25'(ya_q >> 2) - 25'(q100a_q) + 25'(q100a_q >> 2));
    days  = ybase + 25'(month_offset(rec_q.month)) + 25'(rec_q.day);
    tod   = 20'(rec_q.hour * 20'd3600) + 20'(rec_q.minute * 20'd60) + 20'(rec_q.second);
  end

  assign secs_full = days_q * 43'sd86400 + 43'($signed({1'b0, tod_q}));
  assign pop_o     = (state_q == StIdle) && !empty_i;
  assign load      = (state_q == StSecs) && (!valid_o || ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= rec_i;
    if (state_q == StQuot) begin
      q100y_q  <= prod_y[25:19];
      q100a_q  <= prod_a[25:19];
      ya_q     <= ya;
      ya_neg_q <= ya_neg;
    end
    if (state_q == StDays) begin
      days_q <= days;
      tod_q  <= tod;
      ok_q   <= ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_o <= 1'b0;
      secs_o  <= '0;
      err_o   <= 1'b0;
    end else begin
      if (load) valid_o <= 1'b1;
      else if (ready_i) valid_o <= 1'b0;
      unique case (state_q)
        StIdle: if (!empty_i) state_q <= StQuot;
        StQuot: state_q <= StDays;
        StDays: state_q <= StSecs;
        StSecs: begin
          if (load) begin
            secs_o  <= ok_q ? secs_full[38:0] : '0;
            err_o   <= !ok_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== src/http_date_parser.sv =====
// HTTP date parser.
// Input channel: one byte of a date string per item on s_axis; tlast marks the
// final byte. RFC 1123, RFC 850 and asctime layouts are recognized.
// Output channel: one item per string on m_axis, carrying signed epoch seconds
// in tdata and an error flag in tuser; on error the seconds read zero.
// Throughput: the parser takes one byte per cycle while the result queue has
// room. Each string is closed into a queue of QUEUE_DEPTH entries; the epoch
// unit then works through queue pop, quotients, day count, seconds multiply
// and output load for each string before it pops the next one.
// Reset clears the parser state, the queue and the output register; the
// first byte may be taken in the cycle after reset is released.
// When the receiver stalls, the result is held in the output register, the
// epoch unit holds its next result and the queue fills; once full, tready
// drops and input bytes are held back.
module http_date_parser #(
  parameter int unsigned QUEUE_DEPTH = hdp_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tlast_i,   // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [38:0] epoch_seconds, [39] zero pad
  output logic        m_axis_tuser_o    // [0] parse_error
);
  import hdp_pkg::*;

  logic     accept, push, pop, full, empty;
  hdp_rec_t rec_in, rec_out;
  logic [38:0] secs;

  // Stall input only when the queue cannot take a closing string.
  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  hdp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .push_o   (push),
    .rec_o    (rec_in)
  );

  hdp_fifo #(.Depth(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .pop_i   (pop),
    .data_o  (rec_out),
    .full_o  (full),
    .empty_o (empty)
  );

  hdp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .rec_i   (rec_out),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .secs_o  (secs),
    .err_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {1'b0, secs};

endmodule

// ===== src/hdp_checker.sv =====
module hdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // Reset empties the output register at once.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // An error result carries zero seconds.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 40'd0)
    else $error("error result with nonzero seconds");

  // The pad bit above the seconds is always clear.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[39])
    else $error("pad bit set");

  // A stalled item holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output changed");

endmodule

bind http_date_parser hdp_checker u_hdp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
